@@ rtl/core/iss_pkg.sv @@
// iss_pkg: shared types and constants of the idle state selector
// holds the command and status structs between controller and datapath
// no dependencies
package iss_pkg;

  // register index codes, taken from cfg_paddr[3:2]
  localparam logic [1:0] REG_STATE_COUNT = 2'd0;
  localparam logic [1:0] REG_DEMOTE      = 2'd1;
  localparam logic [1:0] REG_PROMOTE     = 2'd2;

  // input item kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SELECT = 1'b1;

  // field widths fixed by the item format
  localparam int unsigned LAT_W  = 20;
  localparam int unsigned DUR_W  = 40;
  localparam int unsigned PCT_W  = 8;
  localparam int unsigned MASK_W = 8;
  localparam int unsigned SEL_W  = 3;

  // full idle percentage
  localparam logic [6:0] PCT_FULL = 7'd100;

  // controller to datapath
  typedef struct packed {
    logic load_entry;   // write table entry from the input transfer
    logic capture;      // latch select fields and the state count
    logic init_nt;      // no table: select 0, flag set
    logic init_presel;  // take saturated preselect index
    logic init_walk;    // start walk at the deepest state
    logic walk_step;    // move walk one state shallower
    logic take_walk;    // current walk state wins
    logic walk_none;    // walk ended without a hit
    logic bias;         // apply promote and demote bias
    logic backoff;      // step one state shallower
    logic publish;      // load the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_zero;
    logic dur_zero;
    logic qualify;
    logic walk_last;
    logic backoff_more;
  } status_t;

endpackage

@@ rtl/core/iss_ctrl.sv @@
// iss_ctrl: sequencing state machine of the idle state selector
// depends on iss_pkg for the command and status structs
module iss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_kind,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  iss_pkg::status_t  status,
  output iss_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_BIAS  = 3'd3;
  localparam logic [2:0] S_BACK  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_tvalid_r, out_tvalid_nxt;
  logic       in_xfer;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign in_xfer    = in_tvalid && in_tready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_kind == iss_pkg::KIND_SELECT) begin
            cmd.capture = 1'b1;
            state_nxt   = S_SETUP;
          end else begin
            cmd.load_entry = 1'b1;
          end
        end
      end
      S_SETUP: begin
        priority if (status.count_zero) begin
          cmd.init_nt = 1'b1;
          state_nxt   = S_DONE;
        end else if (status.dur_zero) begin
          cmd.init_presel = 1'b1;
          state_nxt       = S_BIAS;
        end else begin
          cmd.init_walk = 1'b1;
          state_nxt     = S_WALK;
        end
      end
      S_WALK: begin
        priority if (status.qualify) begin
          cmd.take_walk = 1'b1;
          state_nxt     = S_BIAS;
        end else if (status.walk_last) begin
          cmd.walk_none = 1'b1;
          state_nxt     = S_BIAS;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_BIAS: begin
        cmd.bias  = 1'b1;
        state_nxt = S_BACK;
      end
      S_BACK: begin
        if (status.backoff_more) begin
          cmd.backoff = 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    priority if (cmd.publish) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

`ifndef SYNTHESIS
  // a result is never written over one that still waits
  a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> (!out_tvalid_r || out_tready))
    else $error("output register overwritten");

  // a select transfer always starts the setup step
  a_select_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_kind == iss_pkg::KIND_SELECT) |=> (state_r == S_SETUP))
    else $error("select transfer did not start setup");

  // a load transfer leaves the block ready
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_kind == iss_pkg::KIND_LOAD) |=> (state_r == S_IDLE))
    else $error("load transfer left idle");

  // walk ends at the shallowest state
  a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && status.walk_last) |=> (state_r == S_BIAS))
    else $error("walk ran past the shallowest state");
`endif

endmodule

@@ rtl/core/iss_dp.sv @@
// iss_dp: datapath of the idle state selector
// holds config registers, state table, walk counter, selection and output register
// depends on iss_pkg
module iss_dp #(
  parameter int unsigned MAX_STATES = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_wr,
  input  logic [1:0]                     cfg_index,
  input  logic [31:0]                    cfg_wdata,
  output logic [31:0]                    cfg_rdata,
  // input fields
  input  logic [2:0]                     entry_index,
  input  logic [iss_pkg::LAT_W-1:0]      entry_latency_us,
  input  logic [iss_pkg::LAT_W-1:0]      entry_break_even_us,
  input  logic [iss_pkg::DUR_W-1:0]      idle_duration,
  input  logic [iss_pkg::PCT_W-1:0]      busy_percentage,
  input  logic [iss_pkg::MASK_W-1:0]     test_pass_mask,
  input  logic [iss_pkg::MASK_W-1:0]     available_mask,
  input  logic [7:0]                     preselect_index,
  // control
  input  iss_pkg::cmd_t                  cmd,
  output iss_pkg::status_t               status,
  // result
  output logic [iss_pkg::SEL_W-1:0]      selected_index,
  output logic                           no_table
);

  localparam int unsigned IDX_W = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_STATES + 1);

  // configuration registers
  logic [3:0] state_count_r;
  logic [7:0] demote_r;
  logic [7:0] promote_r;

  // state table
  logic [iss_pkg::LAT_W-1:0] lat_mem [MAX_STATES];
  logic [iss_pkg::LAT_W-1:0] be_mem  [MAX_STATES];

  // captured select item
  logic [iss_pkg::DUR_W-1:0]  dur_r;
  logic [iss_pkg::PCT_W-1:0]  busy_r;
  logic [iss_pkg::MASK_W-1:0] test_r;
  logic [iss_pkg::MASK_W-1:0] avail_r;
  logic [7:0]                 presel_r;
  logic [CNT_W-1:0]           count_r, count_nxt;

  // working registers
  logic [CNT_W-1:0] walk_k_r, walk_k_nxt;
  logic [IDX_W-1:0] sel_r, sel_nxt;
  logic             nt_r, nt_nxt;
  logic [iss_pkg::SEL_W-1:0] out_sel_r;
  logic                      out_nt_r;

  // walk datapath
  logic [IDX_W-1:0]          walk_idx;
  logic [iss_pkg::LAT_W-1:0] lat_rd;
  logic [iss_pkg::LAT_W-1:0] be_rd;
  logic [iss_pkg::LAT_W-1:0] lat_eff;
  logic [24:0]               lat_x20;
  logic [23:0]               be_x10;
  logic                      lat_ok;
  logic                      be_ok;

  // bias datapath
  logic [6:0]       idle_pct;
  logic [7:0]       lo_thr;
  logic [7:0]       hi_thr;
  logic [IDX_W-1:0] bias_sel;
  logic [IDX_W-1:0] presel_sat;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] clamp_sel;
  logic             wr_in_range;

  // state bit from an 8-bit mask, positions 8 and up read as clear
  function automatic logic mask_bit(input logic [iss_pkg::MASK_W-1:0] mask,
                                    input logic [IDX_W-1:0] idx);
    logic [3:0] idx4;
    idx4 = 4'(idx);
    return !idx4[3] && mask[idx4[2:0]];
  endfunction

  // configuration write and read back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_count_r <= '0;
      demote_r      <= '0;
      promote_r     <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        iss_pkg::REG_STATE_COUNT: state_count_r <= cfg_wdata[3:0];
        iss_pkg::REG_DEMOTE:      demote_r      <= cfg_wdata[7:0];
        iss_pkg::REG_PROMOTE:     promote_r     <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      iss_pkg::REG_STATE_COUNT: cfg_rdata = 32'(state_count_r);
      iss_pkg::REG_DEMOTE:      cfg_rdata = 32'(demote_r);
      iss_pkg::REG_PROMOTE:     cfg_rdata = 32'(promote_r);
      default:                  cfg_rdata = '0;
    endcase
  end

  // table write, loads beyond the table are dropped
  assign wr_in_range = (32'(entry_index) < MAX_STATES);

  always_ff @(posedge clk) begin
    if (cmd.load_entry && wr_in_range) begin
      lat_mem[IDX_W'(entry_index)] <= entry_latency_us;
      be_mem[IDX_W'(entry_index)]  <= entry_break_even_us;
    end
  end

  // state count saturates at the table size
  assign count_nxt = (32'(state_count_r) > MAX_STATES) ? CNT_W'(MAX_STATES)
                                                        : CNT_W'(state_count_r);

  // capture select fields
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dur_r    <= idle_duration;
      busy_r   <= busy_percentage;
      test_r   <= test_pass_mask;
      avail_r  <= available_mask;
      presel_r <= preselect_index;
      count_r  <= count_nxt;
    end
  end

  // per-state budget check at the walk position
  assign walk_idx = IDX_W'(walk_k_r - CNT_W'(1));
  assign lat_rd   = lat_mem[walk_idx];
  assign be_rd    = be_mem[walk_idx];
  assign lat_eff  = (lat_rd == '0) ? iss_pkg::LAT_W'(1) : lat_rd;
  assign lat_x20  = {1'b0, lat_eff, 4'b0} + {3'b0, lat_eff, 2'b0};
  assign be_x10   = {1'b0, be_rd, 3'b0} + {3'b0, be_rd, 1'b0};
  assign lat_ok   = (dur_r >= 40'(lat_x20));
  assign be_ok    = (be_rd == '0) || (dur_r >= 40'(be_x10));

  assign last_idx   = IDX_W'(count_r - CNT_W'(1));
  assign presel_sat = (presel_r >= 8'(count_r)) ? last_idx : IDX_W'(presel_r);

  // promote and demote bias
  assign idle_pct = (busy_r > 8'(iss_pkg::PCT_FULL)) ? iss_pkg::PCT_FULL
                                                      : 7'(8'(iss_pkg::PCT_FULL) - busy_r);
  assign lo_thr   = (promote_r < demote_r) ? promote_r : demote_r;
  assign hi_thr   = (promote_r < demote_r) ? demote_r : promote_r;

  always_comb begin
    bias_sel = sel_r;
    priority if (8'(idle_pct) < lo_thr) begin
      bias_sel = '0;
    end else begin
      if (8'(idle_pct) < hi_thr && 32'(count_r) > 2 && 32'(sel_r) > 1) begin
        bias_sel = IDX_W'(1);
      end
      if (32'(bias_sel) >= 32'(count_r)) begin
        bias_sel = last_idx;
      end
    end
  end

  // final clamp to the table size
  assign clamp_sel = (!nt_r && 32'(sel_r) >= 32'(count_r)) ? last_idx : sel_r;

  // working register updates
  always_comb begin
    walk_k_nxt = walk_k_r;
    sel_nxt    = sel_r;
    nt_nxt     = nt_r;
    priority if (cmd.init_nt) begin
      sel_nxt = '0;
      nt_nxt  = 1'b1;
    end else if (cmd.init_presel) begin
      sel_nxt = presel_sat;
      nt_nxt  = 1'b0;
    end else if (cmd.init_walk) begin
      walk_k_nxt = count_r;
      nt_nxt     = 1'b0;
    end else if (cmd.walk_step) begin
      walk_k_nxt = walk_k_r - CNT_W'(1);
    end else if (cmd.take_walk) begin
      sel_nxt = walk_idx;
    end else if (cmd.walk_none) begin
      sel_nxt = '0;
    end else if (cmd.bias) begin
      sel_nxt = bias_sel;
    end else if (cmd.backoff) begin
      sel_nxt = sel_r - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    walk_k_r <= walk_k_nxt;
    sel_r    <= sel_nxt;
    nt_r     <= nt_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_sel_r <= iss_pkg::SEL_W'(clamp_sel);
      out_nt_r  <= nt_r;
    end
  end

  assign selected_index = out_sel_r;
  assign no_table       = out_nt_r;

  // status back to the controller
  assign status.count_zero   = (count_r == '0);
  assign status.dur_zero     = (dur_r == '0);
  assign status.qualify      = lat_ok && be_ok && mask_bit(test_r, walk_idx)
                               && mask_bit(avail_r, walk_idx);
  assign status.walk_last    = (walk_k_r == CNT_W'(1));
  assign status.backoff_more = (sel_r != '0) && !mask_bit(avail_r, sel_r);

endmodule

@@ rtl/core/idle_state_selector.sv @@
// idle_state_selector: top level of the idle state selector
// joins iss_ctrl and iss_dp and packs the stream and register ports
// depends on iss_pkg, iss_ctrl, iss_dp
//
// Usage: the in_ stream carries two kinds of item, told apart by in_tuser.
// A load item (in_tuser 0) writes exit latency and break-even time of one
// table entry and gives no result; the block stays ready. A select item
// (in_tuser 1) gives one result on the out_ stream: the chosen state in
// out_tdata and the no-table flag in out_tuser.
// A select item goes through setup, then with a table either the walk from
// the deepest entry, examining 1 to state_count states, or, when the idle
// time is zero, the saturated preselect index; then bias, back-off over
// unavailable states and the finishing step. With no table, setup leads
// straight to the finishing step. One item is worked at a time; the walk
// and back-off each take one table state per cycle. A finished result waits
// in the output register while the next item is taken; only the finishing
// step waits when the receiver stalls. Reset clears the config registers
// and the controller; table entries stay undefined until loaded. The user
// must write registers over cfg_ only while idle; the block does not check.
module idle_state_selector #(
  parameter int unsigned MAX_STATES = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  // from bit 0: entry_index[2:0], entry_latency_us[22:3],
  // entry_break_even_us[42:23], idle_duration[82:43], busy_percentage[90:83],
  // test_pass_mask[98:91], available_mask[106:99], preselect_index[114:107],
  // zero pad[119:115]
  input  logic [119:0] in_tdata,
  // kind[0]
  input  logic         in_tuser,
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // from bit 0: selected_index[2:0], zero pad[7:3]
  output logic [7:0]   out_tdata,
  // no_table[0]
  output logic         out_tuser,
  // register port
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  iss_pkg::cmd_t    cmd;
  iss_pkg::status_t status;
  logic [iss_pkg::SEL_W-1:0] selected_index;
  logic                      no_table;
  logic                      cfg_wr;

  // register write on the access cycle
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  iss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_kind    (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  iss_dp #(
    .MAX_STATES (MAX_STATES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr              (cfg_wr),
    .cfg_index           (cfg_paddr[3:2]),
    .cfg_wdata           (cfg_pwdata),
    .cfg_rdata           (cfg_prdata),
    .entry_index         (in_tdata[2:0]),
    .entry_latency_us    (in_tdata[22:3]),
    .entry_break_even_us (in_tdata[42:23]),
    .idle_duration       (in_tdata[82:43]),
    .busy_percentage     (in_tdata[90:83]),
    .test_pass_mask      (in_tdata[98:91]),
    .available_mask      (in_tdata[106:99]),
    .preselect_index     (in_tdata[114:107]),
    .cmd                 (cmd),
    .status              (status),
    .selected_index      (selected_index),
    .no_table            (no_table)
  );

  // result packing
  assign out_tdata = {5'b0, selected_index};
  assign out_tuser = no_table;

endmodule

@@ test/iss_tb_pkg.sv @@
// iss_tb_pkg: item and result types plus the selection scoreboard for the selector bench
// keeps its own copy of the state table and registers to predict each chosen state
// depends on iss_pkg
`timescale 1ns / 100ps

package iss_tb_pkg;
  import iss_pkg::*;

  localparam int unsigned TB_STATES = 8;

  // input transfer payload, entry_index in the lowest bits, pad in the highest
  typedef struct packed {
    logic [4:0]  pad;
    logic [7:0]  preselect_index;
    logic [7:0]  available_mask;
    logic [7:0]  test_pass_mask;
    logic [7:0]  busy_percentage;
    logic [39:0] idle_duration;
    logic [19:0] entry_break_even_us;
    logic [19:0] entry_latency_us;
    logic [2:0]  entry_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0] index;
    logic       no_table;
  } choice_t;

  class selection_checker;
    logic [19:0] latency_us [TB_STATES];
    logic [19:0] break_even_us [TB_STATES];
    logic [3:0]  state_count;
    logic [7:0]  demote_pct;
    logic [7:0]  promote_pct;
    choice_t     expected_choices [$];
    int unsigned errors;

    function new();
      foreach (latency_us[i]) begin
        latency_us[i]    = '0;
        break_even_us[i] = '0;
      end
      state_count = '0;
      demote_pct  = '0;
      promote_pct = '0;
      errors      = 0;
    endfunction

    function void note_config(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_STATE_COUNT: state_count = value[3:0];
        REG_DEMOTE:      demote_pct  = value[7:0];
        REG_PROMOTE:     promote_pct = value[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_choices.size();
    endfunction

    // deepest state whose budget, test and availability all fit, else 0
    function int unsigned deepest_fit(int unsigned count, in_item_t it);
      int unsigned i;
      logic [63:0] dur;
      logic [63:0] lat;
      logic [63:0] brk;
      dur = 64'(it.idle_duration);
      for (i = count; i > 0; i--) begin
        lat = (latency_us[i-1] == '0) ? 64'd1 : 64'(latency_us[i-1]);
        brk = 64'(break_even_us[i-1]);
        if (dur >= lat * 64'd20 && (brk == '0 || dur >= brk * 64'd10) &&
            it.test_pass_mask[i-1] && it.available_mask[i-1])
          return i - 1;
      end
      return 0;
    endfunction

    // accepted input: loads update the table, selects queue a predicted choice
    function void note_input(logic kind, in_item_t it);
      int unsigned count;
      int unsigned pick;
      int unsigned idle;
      logic [7:0]  lo;
      logic [7:0]  hi;
      choice_t     res;
      if (kind == KIND_LOAD) begin
        latency_us[it.entry_index]    = it.entry_latency_us;
        break_even_us[it.entry_index] = it.entry_break_even_us;
        return;
      end
      count = (state_count > TB_STATES) ? TB_STATES : int'(state_count);
      if (count == 0) begin
        res.index    = '0;
        res.no_table = 1'b1;
        expected_choices.push_back(res);
        return;
      end
      // budget walk, or the driver's own pick when the idle time is unknown
      if (it.idle_duration == '0)
        pick = (it.preselect_index >= count) ? count - 1 : int'(it.preselect_index);
      else
        pick = deepest_fit(count, it);
      // promote and demote bias toward shallow states
      idle = (it.busy_percentage > 8'd100) ? 100 : 100 - int'(it.busy_percentage);
      lo = demote_pct;
      hi = promote_pct;
      if (hi < lo) begin
        lo = promote_pct;
        hi = demote_pct;
      end
      if (idle < lo) begin
        pick = 0;
      end else begin
        if (idle < hi && count > 2 && pick > 1) pick = 1;
        if (pick >= count) pick = count - 1;
      end
      // back off over unavailable states
      while (pick > 0 && !it.available_mask[pick]) pick--;
      if (pick >= count) pick = count - 1;
      res.index    = 3'(pick);
      res.no_table = 1'b0;
      expected_choices.push_back(res);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [2:0] index, logic flag);
      choice_t want;
      if (expected_choices.size() == 0) begin
        report($sformatf("result index %0d no_table %0b with nothing outstanding",
                         index, flag));
        return;
      end
      want = expected_choices.pop_front();
      if (index !== want.index)
        report($sformatf("selected_index %0d, predicted %0d", index, want.index));
      if (flag !== want.no_table)
        report($sformatf("no_table %0b, predicted %0b", flag, want.no_table));
    endtask
  endclass

endpackage

@@ test/tb_idle_state_selector.sv @@
// tb_idle_state_selector: self-checking bench for the idle state selector
// drives table loads and selects with random idling, checks every result transfer
// depends on iss_pkg, iss_tb_pkg and idle_state_selector
`timescale 1ns / 100ps

module tb_idle_state_selector;
  import iss_pkg::*;
  import iss_tb_pkg::*;

  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned PHASE_ITEMS   = 120;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam logic [39:0] DUR_MAX       = '1;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [119:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [7:0]   out_tdata;
  logic         out_tuser;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [3:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  selection_checker sb;
  bit               idle_on;
  bit               hold_req;
  int unsigned      quiet_cycles;

  idle_state_selector u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[SEL_W-1:0], out_tuser);
  end

  // watchdog on cycles without any transfer or register write
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // receiver: random stall bursts and one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // one input transfer; entered and left at a falling edge
  task automatic send_item(input logic kind, input in_item_t it);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= it;
    do @(posedge clk); while (!in_tready);
    sb.note_input(kind, it);
    @(negedge clk);
  endtask

  // select with directed fields, entry fields left random
  task automatic ask(input logic [39:0] dur, input logic [7:0] busy, input logic [7:0] test,
                     input logic [7:0] avail, input logic [7:0] presel);
    in_item_t it;
    it.pad                 = '0;
    it.entry_index         = 3'($urandom);
    it.entry_latency_us    = 20'($urandom);
    it.entry_break_even_us = 20'($urandom);
    it.idle_duration       = dur;
    it.busy_percentage     = busy;
    it.test_pass_mask      = test;
    it.available_mask      = avail;
    it.preselect_index     = presel;
    send_item(KIND_SELECT, it);
  endtask

  // stop offering and wait until every predicted choice has come back
  task automatic wait_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // register write, setup then access; psel stays up for back-to-back writes
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.note_config(idx, value);
    @(negedge clk);
  endtask

  // all three registers, only once the block has gone quiet
  task automatic reconfigure(input logic [3:0] count, input logic [7:0] demote,
                             input logic [7:0] promote);
    wait_results();
    write_reg(REG_STATE_COUNT, {28'($urandom), count});
    write_reg(REG_DEMOTE, {24'($urandom), demote});
    write_reg(REG_PROMOTE, {24'($urandom), promote});
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // random value with a random number of significant bits
  function automatic logic [39:0] spread(input int unsigned bits);
    logic [63:0] r;
    r = {$urandom, $urandom};
    r = r & ((64'd1 << bits) - 64'd1);
    return 40'(r >> $urandom_range(0, bits - 1));
  endfunction

  function automatic logic [7:0] pick_mask();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom);
      1:       return 8'hFF;
      2:       return 8'($urandom) | 8'($urandom);
      default: return 8'($urandom) & 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_threshold();
    case ($urandom_range(0, 4))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom);
      default: return 8'($urandom_range(0, 100));
    endcase
  endfunction

  task automatic run_random_phase(input int unsigned items);
    in_item_t     it;
    logic [127:0] raw;
    logic         kind;
    repeat (items) begin
      raw = {$urandom, $urandom, $urandom, $urandom};
      it  = in_item_t'(raw[119:0]);
      it.pad = '0;
      kind = ($urandom_range(0, 4) == 0) ? KIND_LOAD : KIND_SELECT;
      // table entries spread over small and large budgets
      case ($urandom_range(0, 2))
        0:       it.entry_latency_us = 20'($urandom_range(0, 1000));
        1:       it.entry_latency_us = 20'(spread(20));
        default: ;
      endcase
      case ($urandom_range(0, 2))
        0:       it.entry_break_even_us = '0;
        1:       it.entry_break_even_us = 20'(spread(20));
        default: ;
      endcase
      // idle time mostly near the table's budgets
      case ($urandom_range(0, 19))
        0, 1:    it.idle_duration = '0;
        2:       it.idle_duration = DUR_MAX;
        default: it.idle_duration = spread($urandom_range(8, 40));
      endcase
      if ($urandom_range(0, 3) != 0) it.busy_percentage = 8'($urandom_range(0, 110));
      it.test_pass_mask = pick_mask();
      it.available_mask = pick_mask();
      if ($urandom_range(0, 1) != 0) it.preselect_index = 8'($urandom_range(0, 9));
      send_item(kind, it);
    end
  endtask

  // stimulus
  initial begin
    in_item_t    it;
    logic [19:0] lat_set [8];
    logic [19:0] brk_set [8];
    logic [3:0]  count;
    sb          = new();
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = KIND_LOAD;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    idle_on     = 1'b1;
    hold_req    = 1'b0;
    lat_set = '{20'd0, 20'd1, 20'd5, 20'd50, 20'd500, 20'd5000, 20'd50000, 20'hFFFFF};
    brk_set = '{20'd0, 20'hFFFFF, 20'd0, 20'd20, 20'd0, 20'd1000, 20'd0, 20'hFFFFF};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // no table after reset
    ask(DUR_MAX, 8'd0, 8'hFF, 8'hFF, 8'd0);
    // fill the whole table before any select can read it
    for (int i = 0; i < 8; i++) begin
      it = '0;
      it.entry_index         = 3'(i);
      it.entry_latency_us    = lat_set[i];
      it.entry_break_even_us = brk_set[i];
      it.idle_duration       = {$urandom, $urandom};
      send_item(KIND_LOAD, it);
    end

    // full table, no bias
    reconfigure(4'd8, 8'd0, 8'd0);
    ask(DUR_MAX, 8'd0, 8'hFF, 8'hFF, 8'd0);
    ask(40'd0, 8'd0, 8'hFF, 8'hFF, 8'd0);
    ask(40'd0, 8'd0, 8'hFF, 8'hFF, 8'd255);
    ask(40'd1, 8'd0, 8'hFF, 8'hFF, 8'd3);
    ask(40'd100, 8'd0, 8'hFF, 8'hFF, 8'd0);
    ask(DUR_MAX, 8'd0, 8'h00, 8'hFF, 8'd0);
    ask(DUR_MAX, 8'd0, 8'hFF, 8'h7F, 8'd0);
    ask(40'd0, 8'd0, 8'hFF, 8'h01, 8'd7);
    ask(40'd0, 8'd255, 8'hFF, 8'h25, 8'd6);
    // demote and promote in order
    reconfigure(4'd8, 8'd50, 8'd80);
    ask(DUR_MAX, 8'd60, 8'hFF, 8'hFF, 8'd0);
    ask(DUR_MAX, 8'd30, 8'hFF, 8'hFF, 8'd0);
    ask(DUR_MAX, 8'd30, 8'hFF, 8'hFD, 8'd0);
    // thresholds out of order, oversized state count
    reconfigure(4'd15, 8'd200, 8'd10);
    ask(DUR_MAX, 8'd255, 8'hFF, 8'hFF, 8'd0);
    ask(DUR_MAX, 8'd95, 8'hFF, 8'hFF, 8'd0);
    ask(40'd0, 8'd101, 8'hFF, 8'hFF, 8'd9);
    // small tables, no cap at index one with two states
    reconfigure(4'd2, 8'd255, 8'd0);
    ask(DUR_MAX, 8'd0, 8'hFF, 8'hFF, 8'd0);
    reconfigure(4'd1, 8'd0, 8'd255);
    ask(DUR_MAX, 8'd0, 8'hFF, 8'hFF, 8'd200);

    // random phases, each under its own register setting
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0:       count = 4'd0;
        1:       count = 4'd8;
        2:       count = 4'd15;
        3:       count = 4'd1;
        default: count = 4'($urandom_range(1, 15));
      endcase
      reconfigure(count, pick_threshold(), pick_threshold());
      idle_on  = (p % 3 != 1) && (p != RANDOM_PHASES - 1);
      hold_req = (p == 2);
      run_random_phase(PHASE_ITEMS);
    end

    wait_results();
    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
